// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the address table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/naa_pkg.sv =====
// Package with constants, codes and control types of the address table.
package naa_pkg;

  // Table size and derived widths
  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int ADDR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Frame commands
  localparam logic [FUNC_W-1:0] FUNC_DISCOVER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CONFIRM  = 2'd1;

  // Reply kinds
  localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADDRESSING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERMINATE  = 2'd2;

  // Confirmation status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_CONFIRM = 2'd3;

  localparam logic [ADDR_W-1:0] TERMINATE_ADDRESS = 8'h00;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the input item, clear the scan
    logic scan_step;  // read one slot and compare the previous one
    logic conf_rd;    // read the slot named by the frame address
    logic commit;     // update the table and load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_done;
    logic              out_busy;
  } sts_t;

endpackage

// ===== rtl/core/naa_if.sv =====
// Handshake interfaces for input frames and result items.
interface naa_in_if;
  logic                       valid;
  logic                       ready;
  logic [naa_pkg::FUNC_W-1:0] func;
  logic [naa_pkg::KEY_W-1:0]  node_key;
  logic [naa_pkg::ADDR_W-1:0] frame_address;

  modport source (output valid, func, node_key, frame_address, input ready);
  modport sink   (input valid, func, node_key, frame_address, output ready);
endinterface

interface naa_out_if;
  logic                         valid;
  logic                         ready;
  logic [naa_pkg::KIND_W-1:0]   reply_kind;
  logic [naa_pkg::ADDR_W-1:0]   reply_address;
  logic [naa_pkg::KEY_W-1:0]    reply_key;
  logic [naa_pkg::STATUS_W-1:0] link_status;

  modport source (output valid, reply_kind, reply_address, reply_key, link_status,
                  input ready);
  modport sink   (input valid, reply_kind, reply_address, reply_key, link_status,
                  output ready);
endinterface

// ===== rtl/core/naa_ctrl.sv =====
// Controller state machine sequencing scan, confirmation and commit.
`include "assert_macros.svh"

module naa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  naa_pkg::sts_t sts_i,
  output naa_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CONF,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Decode commands from the current state
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.conf_rd   = (state_q == ST_CONF);
    cmd_o.commit    = (state_q == ST_FINISH) && !sts_i.out_busy;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts_i.func == naa_pkg::FUNC_DISCOVER) begin
          state_d = ST_SCAN;
        end else if (sts_i.func == naa_pkg::FUNC_CONFIRM) begin
          state_d = ST_CONF;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_FINISH;
      end
      ST_CONF:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_commit_returns_idle, cmd_o.commit, in_ready_o, "commit must return to idle")
  `ASSERT_IMPLIES(a_load_only_idle, cmd_o.load, in_ready_o, "item loaded outside idle")
  `ASSERT_IMPLIES(a_scan_not_conf, cmd_o.scan_step, !cmd_o.conf_rd && !cmd_o.commit,
                  "conflicting commands")

endmodule

// ===== rtl/core/naa_dp.sv =====
// Datapath: slot table, key memory, scan logic and result register.
`include "assert_macros.svh"

module naa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  naa_pkg::cmd_t                  cmd_i,
  output naa_pkg::sts_t                  sts_o,
  input  logic [naa_pkg::FUNC_W-1:0]     func_i,
  input  logic [naa_pkg::KEY_W-1:0]      node_key_i,
  input  logic [naa_pkg::ADDR_W-1:0]     frame_address_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [naa_pkg::KIND_W-1:0]     reply_kind_o,
  output logic [naa_pkg::ADDR_W-1:0]     reply_address_o,
  output logic [naa_pkg::KEY_W-1:0]      reply_key_o,
  output logic [naa_pkg::STATUS_W-1:0]   link_status_o
);

  // Captured item
  logic [naa_pkg::FUNC_W-1:0] func_q;
  logic [naa_pkg::KEY_W-1:0]  key_q;
  logic [naa_pkg::ADDR_W-1:0] addr_q;

  // Slot table
  logic [naa_pkg::KEY_W-1:0]     key_mem [naa_pkg::MAX_SLOTS];
  logic [naa_pkg::MAX_SLOTS-1:0] slot_vld_q;
  logic [naa_pkg::MAX_SLOTS-1:0] slot_rdy_q;

  // Scan state
  logic [naa_pkg::CNT_W-1:0]  cnt_q;
  logic                       cmp_en_q;
  logic                       hit_q;
  logic                       free_found_q;
  logic [naa_pkg::SLOT_W-1:0] free_idx_q;

  // Read port
  logic [naa_pkg::SLOT_W-1:0] rd_idx;
  logic                       rd_en;
  logic                       addr_in_range;
  logic                       cnt_in_range;
  logic [naa_pkg::KEY_W-1:0]  rd_key_q;
  logic                       rd_vld_q;
  logic [naa_pkg::SLOT_W-1:0] rd_idx_q;

  // Result register
  logic                           out_vld_q;
  logic [naa_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [naa_pkg::ADDR_W-1:0]     raddr_q, raddr_d;
  logic [naa_pkg::KEY_W-1:0]      rkey_q, rkey_d;
  logic [naa_pkg::STATUS_W-1:0]   status_q, status_d;

  logic claim;
  logic confirm_ok;

  assign addr_in_range = (addr_q < naa_pkg::ADDR_W'(naa_pkg::MAX_SLOTS));
  assign cnt_in_range  = (cnt_q < naa_pkg::CNT_W'(naa_pkg::MAX_SLOTS));

  // Select the slot to read
  assign rd_idx = cmd_i.scan_step ? cnt_q[naa_pkg::SLOT_W-1:0]
                                  : addr_q[naa_pkg::SLOT_W-1:0];
  assign rd_en  = (cmd_i.scan_step && cnt_in_range) || (cmd_i.conf_rd && addr_in_range);

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (claim) key_mem[free_idx_q] <= key_q;
    if (rd_en) begin
      rd_key_q <= key_mem[rd_idx];
      rd_idx_q <= rd_idx;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= node_key_i;
      addr_q <= frame_address_i;
    end
  end

  // Commit decisions
  assign claim      = cmd_i.commit && (func_q == naa_pkg::FUNC_DISCOVER) &&
                      !hit_q && free_found_q;
  assign confirm_ok = (func_q == naa_pkg::FUNC_CONFIRM) && addr_in_range &&
                      rd_vld_q && (rd_key_q == key_q);

  // Build the result
  always_comb begin
    kind_d   = naa_pkg::KIND_NONE;
    raddr_d  = '0;
    rkey_d   = '0;
    status_d = naa_pkg::ST_NOT_CONFIRM;
    if (func_q == naa_pkg::FUNC_DISCOVER) begin
      if (!hit_q) begin
        rkey_d = key_q;
        if (free_found_q) begin
          kind_d  = naa_pkg::KIND_ADDRESSING;
          raddr_d = naa_pkg::ADDR_W'(free_idx_q);
        end else begin
          kind_d  = naa_pkg::KIND_TERMINATE;
          raddr_d = naa_pkg::TERMINATE_ADDRESS;
        end
      end
    end else if (func_q == naa_pkg::FUNC_CONFIRM) begin
      if (!addr_in_range) begin
        status_d = naa_pkg::ST_BAD_INDEX;
      end else if (confirm_ok) begin
        status_d = naa_pkg::ST_OK;
      end else begin
        status_d = naa_pkg::ST_MISMATCH;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      kind_q   <= kind_d;
      raddr_q  <= raddr_d;
      rkey_q   <= rkey_d;
      status_q <= status_d;
    end
  end

  // Control state: table bits, scan, read valid, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q   <= '0;
      slot_rdy_q   <= '0;
      cnt_q        <= '0;
      cmp_en_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      // Clear the scan on a new item
      if (cmd_i.load) begin
        cnt_q        <= '0;
        cmp_en_q     <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end

      // Advance the scan and compare the slot read last cycle
      if (cmd_i.scan_step) begin
        cmp_en_q <= cnt_in_range;
        if (cnt_in_range) cnt_q <= cnt_q + naa_pkg::CNT_W'(1);
        if (cmp_en_q) begin
          if (rd_vld_q && (rd_key_q == key_q)) hit_q <= 1'b1;
          if (!rd_vld_q && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx_q;
          end
        end
      end

      if (rd_en) rd_vld_q <= slot_vld_q[rd_idx];

      // Claim a slot or mark it ready
      if (claim) begin
        slot_vld_q[free_idx_q] <= 1'b1;
        slot_rdy_q[free_idx_q] <= 1'b0;
      end
      if (cmd_i.commit && confirm_ok) begin
        slot_rdy_q[addr_q[naa_pkg::SLOT_W-1:0]] <= 1'b1;
      end

      // Hold the result until taken
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.scan_done = !cnt_in_range && !cmp_en_q;
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  assign out_valid_o     = out_vld_q;
  assign reply_kind_o    = kind_q;
  assign reply_address_o = raddr_q;
  assign reply_key_o     = rkey_q;
  assign link_status_o   = status_q;

  `ASSERT_IMPLIES(a_claim_free_slot, claim, !slot_vld_q[free_idx_q],
                  "claimed slot is already valid")
  `ASSERT_IMPLIES(a_commit_out_free, cmd_i.commit, !sts_o.out_busy,
                  "result overwritten before taken")
  `ASSERT_ALWAYS(a_ready_needs_valid, (slot_rdy_q & ~slot_vld_q) == '0,
                 "ready bit set on an empty slot")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= naa_pkg::CNT_W'(naa_pkg::MAX_SLOTS),
                 "scan counter past table end")

endmodule

// ===== rtl/core/node_address_assignment_table_top.sv =====
// Top level of the node address assignment table.
//
// Each input item is one bus frame. A discovery frame scans all MAX_SLOTS slots (16) one per
// cycle through the single read port of the key memory before its result is committed; a
// confirmation frame reads the slot named by its frame address, and any other command goes
// straight to commit. Items are processed one at a time: the input is ready only while the
// controller is idle, and a finished result waits in the output register while the next item
// is accepted. Every item gives exactly one result. No clearing pass is needed after reset;
// slot valid and ready bits are cleared at once.
module node_address_assignment_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  naa_in_if.sink     item_i,
  naa_out_if.source  result_o
);

  naa_pkg::cmd_t cmd;
  naa_pkg::sts_t sts;
  logic          in_ready;

  assign item_i.ready = in_ready;

  // Sequence the work on one item
  naa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the table and compute the result
  naa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (item_i.func),
    .node_key_i      (item_i.node_key),
    .frame_address_i (item_i.frame_address),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .reply_kind_o    (result_o.reply_kind),
    .reply_address_o (result_o.reply_address),
    .reply_key_o     (result_o.reply_key),
    .link_status_o   (result_o.link_status)
  );

endmodule
